@@ sv/rpcatb_pkg.sv @@
// ----------------------------------------------------------------------------
// rpcatb_pkg
// Shared types and constants for the remote-call admission filter.
// ----------------------------------------------------------------------------
package rpcatb_pkg;

  // One token in unsigned Q16.16.
  localparam logic [31:0] ONE_TOKEN = 32'h0001_0000;
  localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_REGISTER   = 2'd0,
    FUNC_UNREGISTER = 2'd1,
    FUNC_SET_RATE   = 2'd2,
    FUNC_RECEIVE    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    VERDICT_DELIVERED    = 3'd0,
    VERDICT_TOO_SHORT    = 3'd1,
    VERDICT_OVERSIZED    = 3'd2,
    VERDICT_NO_HANDLER   = 3'd3,
    VERDICT_AUTHORITY    = 3'd4,
    VERDICT_RATE_LIMITED = 3'd5,
    VERDICT_SETUP_DONE   = 3'd6
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_REFILL,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the item and read the tables
    logic check;   // run the receive checks and multiply
    logic refill;  // add, saturate and cap the tokens
    logic finish;  // write the tables back and present the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bucket_active;  // the bucket takes part in this item
  } status_t;

  // One bucket table entry.
  typedef struct packed {
    logic [31:0] rate;
    logic [31:0] capacity;
    logic [31:0] tokens;
    logic [31:0] last_time;
  } bucket_t;

endpackage

@@ sv/rpc_admission_token_bucket_core.sv @@
// ----------------------------------------------------------------------------
// rpc_admission_token_bucket_core
// Admission filter for remote-call messages with a token bucket per call id.
// ----------------------------------------------------------------------------
// Usage. An item is offered on func, rpc_id, sender, msg_length, server_only,
// rate, burst and now, and is taken at a rising edge where start is high and
// busy is low. Items register or unregister a handler, set a bucket's rate
// and burst, or ask whether a message may be delivered.
// Every item gives exactly one result on verdict, out_rpc_id, out_sender and
// payload_length, shown for one cycle with done high. The receiver cannot
// stall, so each result must be taken in the cycle it appears.
// Order: each item passes the table read, the check step and the write-back,
// with the refill step before the write-back when a receive reaches an
// active bucket. The table read, the 32 by 32 refill multiply and the
// saturating add each take a registered step, so one item is in flight at
// a time; busy falls in the cycle the result is shown, so a new item can
// follow at once.
// Configuration: cfg_we with cfg_wdata writes the payload size limit, and is
// to be used only while the block is idle. Reset clears the limit and the
// presence flags of all handlers and all buckets; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rpc_admission_token_bucket_core
  import rpcatb_pkg::*;
#(
  parameter int ID_COUNT = 256
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  rpc_id,
  input  logic [15:0] sender,
  input  logic [15:0] msg_length,
  input  logic        server_only,
  input  logic [31:0] rate,
  input  logic [31:0] burst,
  input  logic [31:0] now,
  output logic        done,
  output logic [2:0]  verdict,
  output logic [7:0]  out_rpc_id,
  output logic [15:0] out_sender,
  output logic [15:0] payload_length
);

  // The controller sequences each item; the datapath holds the tables.
  cmd_t    cmd;
  status_t status;

  rpcatb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  rpcatb_datapath #(
    .ID_COUNT (ID_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .func           (func),
    .rpc_id         (rpc_id),
    .sender         (sender),
    .msg_length     (msg_length),
    .server_only    (server_only),
    .rate           (rate),
    .burst          (burst),
    .now            (now),
    .done           (done),
    .verdict        (verdict),
    .out_rpc_id     (out_rpc_id),
    .out_sender     (out_sender),
    .payload_length (payload_length)
  );

endmodule

@@ sv/rpcatb_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpcatb_ctrl
// Sequencer that steps one item through read, check, refill and write-back.
// ----------------------------------------------------------------------------
module rpcatb_ctrl
  import rpcatb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.check = 1'b1;
        // Only items that reach an active bucket need the refill step.
        if (status.bucket_active) begin
          state_next = ST_REFILL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_REFILL: begin
        cmd.refill = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/rpcatb_datapath.sv @@
// ----------------------------------------------------------------------------
// rpcatb_datapath
// Handler and bucket tables, receive checks and token-bucket arithmetic.
// ----------------------------------------------------------------------------
module rpcatb_datapath
  import rpcatb_pkg::*;
#(
  parameter int ID_COUNT = 256
)
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [1:0]  func,
  input  logic [7:0]  rpc_id,
  input  logic [15:0] sender,
  input  logic [15:0] msg_length,
  input  logic        server_only,
  input  logic [31:0] rate,
  input  logic [31:0] burst,
  input  logic [31:0] now,
  output logic        done,
  output logic [2:0]  verdict,
  output logic [7:0]  out_rpc_id,
  output logic [15:0] out_sender,
  output logic [15:0] payload_length
);

  // Only 256 ids can be named by the 8-bit call id.
  localparam int DEPTH = (ID_COUNT < 256) ? ID_COUNT : 256;
  localparam int IDX_W = $clog2(DEPTH);

  logic [15:0] max_payload_bytes;

  // Reset-cleared flags, one flip-flop per id.
  logic [DEPTH-1:0] handler_present;
  logic [DEPTH-1:0] bucket_present;

  // Stores that are only used while their flag is set.
  logic    handler_server_only [DEPTH];
  bucket_t bucket_mem [DEPTH];

  // Captured item.
  func_t       func_q;
  logic [7:0]  id_q;
  logic        valid_q;
  logic [15:0] sender_q;
  logic [15:0] len_q;
  logic        srv_q;
  logic [31:0] rate_q;
  logic [31:0] burst_q;
  logic [31:0] now_q;

  // Table reads.
  logic    hp_q;
  logic    hso_q;
  logic    bp_q;
  bucket_t entry_q;

  // Intermediate results.
  verdict_t    pre_verdict;
  verdict_t    pre_verdict_q;
  logic        active_q;
  logic [63:0] product;
  logic [31:0] tokens_q;

  logic [IDX_W-1:0] idx_in;
  logic [IDX_W-1:0] idx_q;
  logic             id_valid;
  logic [15:0]      payload;
  logic [31:0]      add_sat;
  logic [32:0]      sum;
  logic [31:0]      sum_sat;
  logic [31:0]      refilled;
  logic             limited;
  logic [31:0]      tokens_left;
  verdict_t         final_verdict;

  assign idx_in   = rpc_id[IDX_W-1:0];
  assign idx_q    = id_q[IDX_W-1:0];
  assign id_valid = ({24'd0, rpc_id} < 32'(ID_COUNT));
  assign payload  = len_q - 16'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes <= '0;
    end else if (cfg_we) begin
      max_payload_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func_t'(func);
      id_q     <= rpc_id;
      valid_q  <= id_valid;
      sender_q <= sender;
      len_q    <= msg_length;
      srv_q    <= server_only;
      rate_q   <= rate;
      burst_q  <= burst;
      now_q    <= now;
      hp_q     <= handler_present[idx_in];
      bp_q     <= bucket_present[idx_in];
      hso_q    <= handler_server_only[idx_in];
      entry_q  <= bucket_mem[idx_in];
    end
  end

  // Receive checks in their fixed order; the first failure decides.
  always_comb begin
    priority if (func_q != FUNC_RECEIVE) begin
      pre_verdict = VERDICT_SETUP_DONE;
    end else if (len_q < 16'd2) begin
      pre_verdict = VERDICT_TOO_SHORT;
    end else if ((max_payload_bytes != 16'd0) && (payload > max_payload_bytes)) begin
      pre_verdict = VERDICT_OVERSIZED;
    end else if (!valid_q || !hp_q) begin
      pre_verdict = VERDICT_NO_HANDLER;
    end else if (hso_q && (sender_q != 16'd0)) begin
      pre_verdict = VERDICT_AUTHORITY;
    end else begin
      pre_verdict = VERDICT_DELIVERED;
    end
  end

  assign status.bucket_active = (pre_verdict == VERDICT_DELIVERED) && bp_q &&
                                (entry_q.rate != 32'd0);

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      pre_verdict_q <= pre_verdict;
      active_q      <= status.bucket_active;
      product       <= 64'(entry_q.rate) * 64'(now_q - entry_q.last_time);
    end
  end

  // Saturating refill, then capped at the bucket capacity.
  assign add_sat  = (product[63:32] != 32'd0) ? SAT32 : product[31:0];
  assign sum      = {1'b0, entry_q.tokens} + {1'b0, add_sat};
  assign sum_sat  = sum[32] ? SAT32 : sum[31:0];
  assign refilled = (sum_sat > entry_q.capacity) ? entry_q.capacity : sum_sat;

  always_ff @(posedge clk) begin
    if (cmd.refill) begin
      tokens_q <= refilled;
    end
  end

  assign limited       = active_q && (tokens_q < ONE_TOKEN);
  assign tokens_left   = limited ? tokens_q : (tokens_q - ONE_TOKEN);
  assign final_verdict = limited ? VERDICT_RATE_LIMITED : pre_verdict_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      handler_present <= '0;
      bucket_present  <= '0;
    end else if (cmd.finish && valid_q) begin
      if (func_q == FUNC_REGISTER) begin
        handler_present[idx_q] <= 1'b1;
      end else if (func_q == FUNC_UNREGISTER) begin
        handler_present[idx_q] <= 1'b0;
      end else if (func_q == FUNC_SET_RATE) begin
        bucket_present[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && valid_q && (func_q == FUNC_REGISTER)) begin
      handler_server_only[idx_q] <= srv_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (valid_q && (func_q == FUNC_SET_RATE)) begin
        bucket_mem[idx_q] <= '{rate: rate_q, capacity: burst_q, tokens: burst_q,
                               last_time: now_q};
      end else if (active_q) begin
        bucket_mem[idx_q] <= '{rate: entry_q.rate, capacity: entry_q.capacity,
                               tokens: tokens_left, last_time: now_q};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      verdict    <= final_verdict;
      out_rpc_id <= id_q;
      if (final_verdict == VERDICT_DELIVERED) begin
        out_sender     <= sender_q;
        payload_length <= payload;
      end else begin
        out_sender     <= '0;
        payload_length <= '0;
      end
    end
  end

endmodule
